// ===== sv/pde_pkg.sv =====
`timescale 1ns / 1ps
package pde_pkg;

	localparam int MAX_POINTS_DEF = 32;
	localparam int COORD_BITS_DEF = 16;
	localparam int FIELD_W = 16;
	localparam int THR_W = 17;
	localparam int IDX_W = 5;
	localparam int DIST_W = 17;
	localparam int SQ_KEEP = 35;

	typedef enum logic [2:0] {
		KIND_NEAR     = 3'd0,
		KIND_CLOSEST  = 3'd1,
		KIND_FARTHEST = 3'd2,
		KIND_FEW      = 3'd3,
		KIND_DROPPED  = 3'd4
	} kind_t;

	typedef enum logic [1:0] {
		SRC_PEND,
		SRC_CLOSE,
		SRC_FAR,
		SRC_ZERO
	} src_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_RD,
		ST_DIF,
		ST_MUL,
		ST_ADD,
		ST_CMP,
		ST_STASH,
		ST_NEXT,
		ST_ENDP,
		ST_FIN,
		ST_FAR,
		ST_CLR,
		ST_DROP,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic signed [FIELD_W-1:0] x_coord;
		logic signed [FIELD_W-1:0] y_coord;
		logic                      last_point;
	} in_word_t;

	typedef struct packed {
		kind_t              kind;
		logic [IDX_W-1:0]   first_index;
		logic [IDX_W-1:0]   second_index;
		logic [DIST_W-1:0]  distance;
		logic               last_result;
	} out_word_t;

	typedef struct packed {
		logic  accept;
		logic  dif_en;
		logic  mul_en;
		logic  add_en;
		logic  cmp_en;
		logic  stash;
		logic  idx_inc;
		logic  store;
		logic  clear_set;
		logic  em_start;
		src_t  em_src;
		kind_t em_kind;
		logic  em_last;
		logic  out_load;
	} dp_cmd_t;

	typedef struct packed {
		logic full;
		logic cnt_zero;
		logic cnt_ge2;
		logic near;
		logic pend_v;
		logic idx_last;
		logic sqrt_done;
		logic out_free;
		logic last_pt;
	} dp_sts_t;

endpackage

// ===== sv/pde_ram.sv =====
`timescale 1ns / 1ps
module pde_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata_q
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end
endmodule

// ===== sv/pde_sqrt.sv =====
`timescale 1ns / 1ps
module pde_sqrt #(
	parameter int W = 34
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  logic [W-1:0]   op,
	output logic           busy,
	output logic [W/2-1:0] root
);
	logic [W-1:0] n_q, res_q, bit_q, trial;
	logic         busy_q, ge;

	assign trial = res_q + bit_q;
	assign ge    = n_q >= trial;
	assign busy  = busy_q;
	assign root  = res_q[W/2-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (start) begin
			busy_q <= 1'b1;
		end else if (busy_q) begin
			busy_q <= |bit_q[W-1:2];
		end
	end

	// one result bit per cycle, two operand bits consumed
	always_ff @(posedge clk) begin
		if (start) begin
			n_q   <= op;
			res_q <= '0;
			bit_q <= W'(1) << (W - 2);
		end else if (busy_q) begin
			n_q   <= ge ? n_q - trial : n_q;
			res_q <= ge ? (res_q >> 1) + bit_q : res_q >> 1;
			bit_q <= bit_q >> 2;
		end
	end
endmodule

// ===== sv/pde_dp.sv =====
`timescale 1ns / 1ps
module pde_dp #(
	parameter int MAX_POINTS = 32,
	parameter int COORD_BITS = 16
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  pde_pkg::dp_cmd_t         cmd,
	output pde_pkg::dp_sts_t         sts,
	input  pde_pkg::in_word_t        in_word,
	input  logic                     out_stall,
	output logic                     out_valid,
	output pde_pkg::out_word_t       out_word,
	input  logic                     cfg_wen,
	input  logic [pde_pkg::THR_W-1:0] cfg_wdata
);
	import pde_pkg::*;

	localparam int CB     = COORD_BITS;
	localparam int CNT_W  = $clog2(MAX_POINTS + 1);
	localparam int AW     = $clog2(MAX_POINTS);
	localparam int SQ_W   = 2 * CB + 1;
	localparam int EXT_W  = (SQ_W < SQ_KEEP) ? SQ_W : SQ_KEEP;
	localparam int THR2_W = 2 * THR_W;
	localparam int CMP_W  = (SQ_W > THR2_W) ? SQ_W : THR2_W;
	localparam int RW     = SQ_W + (SQ_W % 2);

	logic [CNT_W-1:0]     cnt_q, idx_q;
	logic signed [CB-1:0] px_q, py_q;
	logic                 last_q;
	logic [2*CB-1:0]      rd_data;
	logic signed [CB-1:0] sx, sy;
	logic signed [CB:0]   ddx, ddy;
	logic [CB-1:0]        dx_q, dy_q;
	logic [2*CB-1:0]      sqx_q, sqy_q;
	logic [SQ_W-1:0]      sq_q;
	logic [THR2_W-1:0]    thr2_q, thr2_d;
	logic [EXT_W-1:0]     cl_sq_q, far_sq_q;
	logic [CNT_W-1:0]     cl_f_q, cl_s_q, far_f_q, far_s_q;
	logic [CNT_W-1:0]     pend_f_q, pend_s_q;
	logic [SQ_W-1:0]      pend_sq_q;
	logic                 pend_v_q;
	kind_t                em_kind_q;
	logic [CNT_W-1:0]     em_f_q, em_s_q;
	logic                 em_last_q;
	logic [RW-1:0]        sq_op;
	logic                 sq_busy;
	logic [RW/2-1:0]      root;
	logic                 out_v_q, out_free;
	out_word_t            out_q;
	logic                 cl_upd, far_upd;

	pde_ram #(.WIDTH(2 * CB), .DEPTH(MAX_POINTS)) u_store (
		.clk    (clk),
		.we     (cmd.store),
		.waddr  (cnt_q[AW-1:0]),
		.wdata  ({px_q, py_q}),
		.raddr  (idx_q[AW-1:0]),
		.rdata_q(rd_data)
	);

	assign sx  = rd_data[2*CB-1:CB];
	assign sy  = rd_data[CB-1:0];
	assign ddx = {px_q[CB-1], px_q} - {sx[CB-1], sx};
	assign ddy = {py_q[CB-1], py_q} - {sy[CB-1], sy};

	assign thr2_d = THR2_W'(cfg_wdata) * THR2_W'(cfg_wdata);

	assign cl_upd = (sq_q < SQ_W'(cl_sq_q)) ||
	                ((sq_q == SQ_W'(cl_sq_q)) && (idx_q < cl_f_q));
	assign far_upd = (sq_q > SQ_W'(far_sq_q)) ||
	                 ((sq_q == SQ_W'(far_sq_q)) && (idx_q < far_f_q));

	always_comb begin
		case (cmd.em_src)
			SRC_PEND:  sq_op = RW'(pend_sq_q);
			SRC_CLOSE: sq_op = RW'(cl_sq_q);
			SRC_FAR:   sq_op = RW'(far_sq_q);
			default:   sq_op = '0;
		endcase
	end

	pde_sqrt #(.W(RW)) u_sqrt (
		.clk   (clk),
		.arst_n(arst_n),
		.start (cmd.em_start),
		.op    (sq_op),
		.busy  (sq_busy),
		.root  (root)
	);

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			px_q   <= CB'($unsigned(in_word.x_coord));
			py_q   <= CB'($unsigned(in_word.y_coord));
			last_q <= in_word.last_point;
		end
		if (cmd.dif_en) begin
			dx_q <= CB'(ddx[CB] ? -ddx : ddx);
			dy_q <= CB'(ddy[CB] ? -ddy : ddy);
		end
		if (cmd.mul_en) begin
			sqx_q <= dx_q * dx_q;
			sqy_q <= dy_q * dy_q;
		end
		if (cmd.add_en) begin
			sq_q <= SQ_W'(sqx_q) + SQ_W'(sqy_q);
		end
		if (cmd.stash) begin
			pend_f_q  <= idx_q;
			pend_s_q  <= cnt_q;
			pend_sq_q <= sq_q;
		end
		if (cmd.em_start) begin
			em_kind_q <= cmd.em_kind;
			em_last_q <= cmd.em_last;
			case (cmd.em_src)
				SRC_PEND: begin
					em_f_q <= pend_f_q;
					em_s_q <= pend_s_q;
				end
				SRC_CLOSE: begin
					em_f_q <= cl_f_q;
					em_s_q <= cl_s_q;
				end
				SRC_FAR: begin
					em_f_q <= far_f_q;
					em_s_q <= far_s_q;
				end
				default: begin
					em_f_q <= '0;
					em_s_q <= '0;
				end
			endcase
		end
		if (cmd.out_load) begin
			out_q.kind         <= em_kind_q;
			out_q.first_index  <= IDX_W'(em_f_q);
			out_q.second_index <= IDX_W'(em_s_q);
			out_q.distance     <= DIST_W'(root);
			out_q.last_result  <= em_last_q;
		end
	end

	// control and set state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q    <= '0;
			idx_q    <= '0;
			pend_v_q <= 1'b0;
			thr2_q   <= '0;
			cl_sq_q  <= '0;
			cl_f_q   <= '0;
			cl_s_q   <= '0;
			far_sq_q <= '0;
			far_f_q  <= '0;
			far_s_q  <= '0;
			out_v_q  <= 1'b0;
		end else begin
			if (cfg_wen) begin
				thr2_q <= thr2_d;
			end
			if (cmd.accept) begin
				idx_q    <= '0;
				pend_v_q <= 1'b0;
			end else if (cmd.idx_inc) begin
				idx_q <= idx_q + CNT_W'(1);
			end
			if (cmd.stash) begin
				pend_v_q <= 1'b1;
			end
			if (cmd.cmp_en) begin
				if (cnt_q == CNT_W'(1) || cl_upd) begin
					cl_sq_q <= EXT_W'(sq_q);
					cl_f_q  <= idx_q;
					cl_s_q  <= cnt_q;
				end
				if (cnt_q == CNT_W'(1) || far_upd) begin
					far_sq_q <= EXT_W'(sq_q);
					far_f_q  <= idx_q;
					far_s_q  <= cnt_q;
				end
			end
			if (cmd.clear_set) begin
				cnt_q    <= '0;
				cl_sq_q  <= '0;
				cl_f_q   <= '0;
				cl_s_q   <= '0;
				far_sq_q <= '0;
				far_f_q  <= '0;
				far_s_q  <= '0;
			end else if (cmd.store) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end
			if (cmd.out_load) begin
				out_v_q <= 1'b1;
			end else if (!out_stall) begin
				out_v_q <= 1'b0;
			end
		end
	end

	assign out_free  = !out_v_q || !out_stall;
	assign out_valid = out_v_q;
	assign out_word  = out_q;

	assign sts.full      = cnt_q == CNT_W'(MAX_POINTS);
	assign sts.cnt_zero  = cnt_q == '0;
	assign sts.cnt_ge2   = cnt_q >= CNT_W'(2);
	assign sts.near      = CMP_W'(sq_q) <= CMP_W'(thr2_q);
	assign sts.pend_v    = pend_v_q;
	assign sts.idx_last  = CNT_W'(idx_q + CNT_W'(1)) == cnt_q;
	assign sts.sqrt_done = !sq_busy;
	assign sts.out_free  = out_free;
	assign sts.last_pt   = last_q;
endmodule

// ===== sv/pde_ctrl.sv =====
`timescale 1ns / 1ps
module pde_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  pde_pkg::dp_sts_t sts,
	output pde_pkg::dp_cmd_t cmd
);
	import pde_pkg::*;

	state_t state_q, state_d, ret_q, ret_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ret_q   <= ST_IDLE;
		end else begin
			state_q <= state_d;
			ret_q   <= ret_d;
		end
	end

	assign in_stall = state_q != ST_IDLE;

	always_comb begin
		state_d = state_q;
		ret_d   = ret_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.accept = 1'b1;
					if (sts.full) begin
						state_d = ST_DROP;
					end else if (sts.cnt_zero) begin
						state_d = ST_ENDP;
					end else begin
						state_d = ST_RD;
					end
				end
			end
			ST_RD: state_d = ST_DIF;
			ST_DIF: begin
				cmd.dif_en = 1'b1;
				state_d    = ST_MUL;
			end
			ST_MUL: begin
				cmd.mul_en = 1'b1;
				state_d    = ST_ADD;
			end
			ST_ADD: begin
				cmd.add_en = 1'b1;
				state_d    = ST_CMP;
			end
			ST_CMP: begin
				cmd.cmp_en = 1'b1;
				if (sts.near && sts.pend_v) begin
					// flush the held near pair; it is not the final word
					cmd.em_start = 1'b1;
					cmd.em_src   = SRC_PEND;
					cmd.em_kind  = KIND_NEAR;
					ret_d        = ST_STASH;
					state_d      = ST_EMIT;
				end else if (sts.near) begin
					state_d = ST_STASH;
				end else begin
					state_d = ST_NEXT;
				end
			end
			ST_STASH: begin
				cmd.stash = 1'b1;
				state_d   = ST_NEXT;
			end
			ST_NEXT: begin
				cmd.idx_inc = 1'b1;
				state_d     = sts.idx_last ? ST_ENDP : ST_RD;
			end
			ST_ENDP: begin
				cmd.store = 1'b1;
				if (sts.pend_v) begin
					cmd.em_start = 1'b1;
					cmd.em_src   = SRC_PEND;
					cmd.em_kind  = KIND_NEAR;
					cmd.em_last  = !sts.last_pt;
					ret_d        = ST_FIN;
					state_d      = ST_EMIT;
				end else begin
					state_d = ST_FIN;
				end
			end
			ST_DROP: begin
				cmd.em_start = 1'b1;
				cmd.em_src   = SRC_ZERO;
				cmd.em_kind  = KIND_DROPPED;
				cmd.em_last  = !sts.last_pt;
				ret_d        = ST_FIN;
				state_d      = ST_EMIT;
			end
			ST_FIN: begin
				if (!sts.last_pt) begin
					state_d = ST_IDLE;
				end else if (sts.cnt_ge2) begin
					cmd.em_start = 1'b1;
					cmd.em_src   = SRC_CLOSE;
					cmd.em_kind  = KIND_CLOSEST;
					ret_d        = ST_FAR;
					state_d      = ST_EMIT;
				end else begin
					cmd.em_start = 1'b1;
					cmd.em_src   = SRC_ZERO;
					cmd.em_kind  = KIND_FEW;
					cmd.em_last  = 1'b1;
					ret_d        = ST_CLR;
					state_d      = ST_EMIT;
				end
			end
			ST_FAR: begin
				cmd.em_start = 1'b1;
				cmd.em_src   = SRC_FAR;
				cmd.em_kind  = KIND_FARTHEST;
				cmd.em_last  = 1'b1;
				ret_d        = ST_CLR;
				state_d      = ST_EMIT;
			end
			ST_CLR: begin
				cmd.clear_set = 1'b1;
				state_d       = ST_IDLE;
			end
			ST_EMIT: begin
				if (sts.sqrt_done && sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = ret_q;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end
endmodule

// ===== sv/pairwise_distance_extremes.sv =====
`timescale 1ns / 1ps
// Brute-force closest/farthest pair finder. Each input word is a point; it is
// measured against every earlier point of the current set (stored in a small
// RAM), near pairs (distance <= near_threshold) are reported in order of the
// earlier index, and a word with last_point set closes the set with a closest
// and a farthest word (or a too-few-points word) and clears it. Points past
// MAX_POINTS are dropped with a flag word. Distances are exact on squares and
// reported as the truncated square root, in 1/16 units. Each stored point is
// taken through the read/difference/square/sum/compare sequence, and each
// reported word waits on the shared iterative square-root unit and on any
// output stall. The block takes one point at a time.
module pairwise_distance_extremes #(
	parameter int MAX_POINTS = pde_pkg::MAX_POINTS_DEF,
	parameter int COORD_BITS = pde_pkg::COORD_BITS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  pde_pkg::in_word_t         in_word,
	output logic                      out_valid,
	input  logic                      out_stall,
	output pde_pkg::out_word_t        out_word,
	input  logic                      cfg_wen,
	input  logic [pde_pkg::THR_W-1:0] cfg_wdata
);
	import pde_pkg::*;

	dp_cmd_t cmd;
	dp_sts_t sts;

	// sequencer: walks stored points, issues emits, waits on sqrt and output
	pde_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.sts     (sts),
		.cmd     (cmd)
	);

	// datapath: point store, distance math, extremes, output word register
	pde_dp #(
		.MAX_POINTS(MAX_POINTS),
		.COORD_BITS(COORD_BITS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.sts      (sts),
		.in_word  (in_word),
		.out_stall(out_stall),
		.out_valid(out_valid),
		.out_word (out_word),
		.cfg_wen  (cfg_wen),
		.cfg_wdata(cfg_wdata)
	);
endmodule
